FILE: rtl/core/lpf_pkg.sv
// shared types and constants for the log line pattern filter
`default_nettype none

package lpf_pkg;

  // pattern storage is three 64-bit registers
  localparam int PAT_BYTES = 24;
  localparam int PAT_W     = 8 * PAT_BYTES;

  // common compare width for columns, spans and line length
  localparam int SPAN_W = 12;

  // wide enough for a span count up to the largest capture depth
  localparam int CNT_W = 7;

  // line terminators
  localparam logic [7:0] BYTE_LF  = 8'h0a;
  localparam logic [7:0] BYTE_NUL = 8'h00;

  // result kinds
  localparam logic [1:0] KIND_DATE_BYTE = 2'd0;
  localparam logic [1:0] KIND_TIME_BYTE = 2'd1;
  localparam logic [1:0] KIND_DATE_BAD  = 2'd2;
  localparam logic [1:0] KIND_TIME_BAD  = 2'd3;

  // configuration register indexes
  localparam logic [2:0] REG_PATTERN_LOW    = 3'd0;
  localparam logic [2:0] REG_PATTERN_MID    = 3'd1;
  localparam logic [2:0] REG_PATTERN_HIGH   = 3'd2;
  localparam logic [2:0] REG_PATTERN_LENGTH = 3'd3;
  localparam logic [2:0] REG_DATE_START     = 3'd4;
  localparam logic [2:0] REG_DATE_END       = 3'd5;
  localparam logic [2:0] REG_TIME_START     = 3'd6;
  localparam logic [2:0] REG_TIME_END       = 3'd7;

  typedef struct packed {
    logic [PAT_W-1:0] pattern;
    logic [4:0]       pattern_length;
    logic [9:0]       date_start;
    logic [10:0]      date_end;
    logic [9:0]       time_start;
    logic [10:0]      time_end;
  } cfg_t;

  // span summary of a matching line, handed to the emitter
  typedef struct packed {
    logic             date_ok;
    logic [CNT_W-1:0] date_last;
    logic             time_ok;
    logic [CNT_W-1:0] time_last;
  } job_t;

  // pattern byte k, zero beyond the stored bytes
  function automatic logic [7:0] pat_byte(input logic [PAT_W-1:0] p, input logic [4:0] k);
    logic [255:0] ext;
    ext = {{(256 - PAT_W){1'b0}}, p};
    return ext[{k, 3'b000} +: 8];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/lpf_line.sv
// line tracker: window compare, column capture and line end summary
`default_nettype none

module lpf_line
  import lpf_pkg::*;
#(
  parameter int PATTERN_MAX = 24,
  parameter int CAPTURE_MAX = 16,
  parameter int LINE_MAX    = 1024
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire cfg_t       cfg,
  input  wire logic       in_beat,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_eos,
  input  wire logic       job_take,
  output logic            job_pend,
  output job_t            job,
  output logic [7:0]      date_buf [CAPTURE_MAX],
  output logic [7:0]      time_buf [CAPTURE_MAX]
);

  localparam int LPW = $clog2(LINE_MAX + 1);
  localparam int PLW = $clog2(PATTERN_MAX + 32);
  localparam int CIW = (CAPTURE_MAX > 1) ? $clog2(CAPTURE_MAX) : 1;
  localparam int HW  = LPW + PLW;

  logic [LPW-1:0] line_pos;
  logic           seen;
  logic [7:0]     recent [PATTERN_MAX];

  logic [LPW-1:0]    pos_next;
  logic              col_ok;
  logic              line_end;
  logic [PLW-1:0]    plen;
  logic              mismatch;
  logic              hit;
  logic [SPAN_W-1:0] col_w;
  logic [SPAN_W-1:0] len_w;
  logic              date_cap;
  logic              time_cap;
  logic [SPAN_W-1:0] date_off;
  logic [SPAN_W-1:0] time_off;
  job_t              job_next;

  function automatic logic in_span(input logic [SPAN_W-1:0] col, input logic [SPAN_W-1:0] s,
                                   input logic [SPAN_W-1:0] e);
    return (col >= s) && (col < e) && ((col - s) < SPAN_W'(CAPTURE_MAX));
  endfunction

  function automatic logic span_ok(input logic [SPAN_W-1:0] s, input logic [SPAN_W-1:0] e,
                                   input logic [SPAN_W-1:0] len);
    return (e > s) && (e != '0) && (s < len) && (e <= len);
  endfunction

  function automatic logic [CNT_W-1:0] span_last(input logic [SPAN_W-1:0] s,
                                                 input logic [SPAN_W-1:0] e);
    logic [SPAN_W-1:0] diff;
    diff = e - s;
    if (diff > SPAN_W'(CAPTURE_MAX)) begin
      diff = SPAN_W'(CAPTURE_MAX);
    end
    return CNT_W'(diff - SPAN_W'(1));
  endfunction

  assign line_end = (in_byte == BYTE_LF) || (in_byte == BYTE_NUL);
  assign col_ok   = line_pos < LPW'(LINE_MAX);
  assign pos_next = col_ok ? line_pos + LPW'(1) : line_pos;
  assign col_w    = SPAN_W'(line_pos);
  assign len_w    = SPAN_W'(line_pos);

  // effective pattern length, clamped to 1..PATTERN_MAX
  always_comb begin
    if (cfg.pattern_length == 5'd0) begin
      plen = PLW'(1);
    end else if (PLW'(cfg.pattern_length) > PLW'(PATTERN_MAX)) begin
      plen = PLW'(PATTERN_MAX);
    end else begin
      plen = PLW'(cfg.pattern_length);
    end
  end

  // window slot j holds the byte that must equal pattern byte plen-1-j
  always_comb begin
    logic [4:0] pidx;
    logic [7:0] wb;
    mismatch = 1'b0;
    pidx     = '0;
    wb       = '0;
    for (int j = 0; j < PATTERN_MAX; j++) begin
      wb   = (j == 0) ? in_byte : recent[(j == 0) ? 0 : j - 1];
      pidx = 5'(plen - PLW'(1) - PLW'(j));
      if ((PLW'(j) < plen) && (wb != pat_byte(cfg.pattern, pidx))) begin
        mismatch = 1'b1;
      end
    end
  end

  assign hit = (HW'(pos_next) >= HW'(plen)) && !mismatch;

  assign date_cap = col_ok && in_span(col_w, SPAN_W'(cfg.date_start), SPAN_W'(cfg.date_end));
  assign time_cap = col_ok && in_span(col_w, SPAN_W'(cfg.time_start), SPAN_W'(cfg.time_end));
  assign date_off = col_w - SPAN_W'(cfg.date_start);
  assign time_off = col_w - SPAN_W'(cfg.time_start);

  always_comb begin
    job_next.date_ok   = span_ok(SPAN_W'(cfg.date_start), SPAN_W'(cfg.date_end), len_w);
    job_next.date_last = span_last(SPAN_W'(cfg.date_start), SPAN_W'(cfg.date_end));
    job_next.time_ok   = span_ok(SPAN_W'(cfg.time_start), SPAN_W'(cfg.time_end), len_w);
    job_next.time_last = span_last(SPAN_W'(cfg.time_start), SPAN_W'(cfg.time_end));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_pos <= '0;
      seen     <= 1'b0;
      job_pend <= 1'b0;
    end else begin
      if (job_take) begin
        job_pend <= 1'b0;
      end
      if (in_beat) begin
        if (in_eos || line_end) begin
          if (!in_eos && seen) begin
            job_pend <= 1'b1;
          end
          line_pos <= '0;
          seen     <= 1'b0;
        end else begin
          line_pos <= pos_next;
          if (hit) begin
            seen <= 1'b1;
          end
        end
      end
    end
  end

  // payload: window, capture buffers and line summary
  always_ff @(posedge clk) begin
    if (in_beat && !in_eos) begin
      if (line_end) begin
        job <= job_next;
      end else begin
        recent[0] <= in_byte;
        for (int j = 1; j < PATTERN_MAX; j++) begin
          recent[j] <= recent[j - 1];
        end
        if (date_cap) begin
          date_buf[CIW'(date_off)] <= in_byte;
        end
        if (time_cap) begin
          time_buf[CIW'(time_off)] <= in_byte;
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/lpf_emit.sv
// result sequencer: date span then time span into the output register
`default_nettype none

module lpf_emit
  import lpf_pkg::*;
#(
  parameter int CAPTURE_MAX = 16
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       job_pend,
  input  wire job_t       job,
  input  wire logic [7:0] date_buf [CAPTURE_MAX],
  input  wire logic [7:0] time_buf [CAPTURE_MAX],
  output logic            job_take,
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata,
  output logic [1:0]      m_tuser,
  output logic            m_tlast
);

  localparam int CIW = (CAPTURE_MAX > 1) ? $clog2(CAPTURE_MAX) : 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DATE,
    ST_TIME
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] idx;
  job_t             jb;
  logic [7:0]       dbuf [CAPTURE_MAX];
  logic [7:0]       tbuf [CAPTURE_MAX];
  logic             advance;

  assign job_take = (state == ST_IDLE) && job_pend;
  assign advance  = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (job_take) begin
      jb   <= job;
      dbuf <= date_buf;
      tbuf <= time_buf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
      idx      <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          // last beat of the previous run leaves here
          if (m_tready) begin
            m_tvalid <= 1'b0;
          end
          if (job_pend) begin
            idx   <= '0;
            state <= ST_DATE;
          end
        end
        ST_DATE: begin
          if (advance) begin
            m_tvalid <= 1'b1;
            m_tlast  <= 1'b0;
            if (jb.date_ok) begin
              m_tuser <= KIND_DATE_BYTE;
              m_tdata <= dbuf[CIW'(idx)];
              if (idx == jb.date_last) begin
                idx   <= '0;
                state <= ST_TIME;
              end else begin
                idx <= idx + CNT_W'(1);
              end
            end else begin
              m_tuser <= KIND_DATE_BAD;
              m_tdata <= '0;
              idx     <= '0;
              state   <= ST_TIME;
            end
          end
        end
        ST_TIME: begin
          if (advance) begin
            m_tvalid <= 1'b1;
            if (jb.time_ok) begin
              m_tuser <= KIND_TIME_BYTE;
              m_tdata <= tbuf[CIW'(idx)];
              if (idx == jb.time_last) begin
                m_tlast <= 1'b1;
                idx     <= '0;
                state   <= ST_IDLE;
              end else begin
                m_tlast <= 1'b0;
                idx     <= idx + CNT_W'(1);
              end
            end else begin
              m_tuser <= KIND_TIME_BAD;
              m_tdata <= '0;
              m_tlast <= 1'b1;
              idx     <= '0;
              state   <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/log_line_pattern_filter_top.sv
// log line pattern filter: top level with configuration registers
// result path: a byte is absorbed in the cycle its beat is taken; a matching line's
//   results pass the pending summary, the emitter handoff and date state to the output
// throughput: one byte per cycle while s_tready is high; input stalls after a matching
//   line end until taken, longer while prior results (up to 2*CAPTURE_MAX beats) drain
// reset: line state, handoff and output valid cleared, registers to defaults, no clearing pass
`default_nettype none

module log_line_pattern_filter_top
  import lpf_pkg::*;
#(
  parameter int PATTERN_MAX = 24,
  parameter int CAPTURE_MAX = 16,
  parameter int LINE_MAX    = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration write port
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data,
  // byte stream in
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
  input  wire logic [0:0]  s_tuser,   // [0] end_of_stream
  // results out
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,   // [7:0] result_byte
  output logic [1:0]       m_tuser,   // [1:0] result_kind
  output logic             m_tlast    // last_of_run
);

  cfg_t       cfg;
  logic       in_beat;
  logic       job_pend;
  logic       job_take;
  job_t       job;
  logic [7:0] date_buf [CAPTURE_MAX];
  logic [7:0] time_buf [CAPTURE_MAX];

  // configuration registers; the user writes them only while the block is quiet, the block does not enforce it
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pattern        <= '0;
      cfg.pattern_length <= 5'd1;
      cfg.date_start     <= 10'd0;
      cfg.date_end       <= 11'd6;
      cfg.time_start     <= 10'd8;
      cfg.time_end       <= 11'd16;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PATTERN_LOW:    cfg.pattern[63:0]    <= cfg_data;
        REG_PATTERN_MID:    cfg.pattern[127:64]  <= cfg_data;
        REG_PATTERN_HIGH:   cfg.pattern[191:128] <= cfg_data;
        REG_PATTERN_LENGTH: cfg.pattern_length   <= cfg_data[4:0];
        REG_DATE_START:     cfg.date_start       <= cfg_data[9:0];
        REG_DATE_END:       cfg.date_end         <= cfg_data[10:0];
        REG_TIME_START:     cfg.time_start       <= cfg_data[9:0];
        REG_TIME_END:       cfg.time_end         <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  // input holds off only while a finished line waits for the emitter
  assign s_tready = !job_pend;
  assign in_beat  = s_tvalid && s_tready;

  // window compare, column capture and line end summary
  lpf_line #(
    .PATTERN_MAX(PATTERN_MAX),
    .CAPTURE_MAX(CAPTURE_MAX),
    .LINE_MAX   (LINE_MAX)
  ) u_line (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .in_beat (in_beat),
    .in_byte (s_tdata),
    .in_eos  (s_tuser[0]),
    .job_take(job_take),
    .job_pend(job_pend),
    .job     (job),
    .date_buf(date_buf),
    .time_buf(time_buf)
  );

  // copies the captured spans and streams them out while the next line comes in
  lpf_emit #(
    .CAPTURE_MAX(CAPTURE_MAX)
  ) u_emit (
    .clk     (clk),
    .rst     (rst),
    .job_pend(job_pend),
    .job     (job),
    .date_buf(date_buf),
    .time_buf(time_buf),
    .job_take(job_take),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
  );

`ifndef SYNTHESIS
  // a handoff clears the waiting line summary on the next edge
  a_take_clears: assert property (@(posedge clk) disable iff (rst)
    job_take |=> !job_pend)
    else $error("line summary still pending after handoff");

  // the final beat of a run always belongs to the time span
  a_last_is_time: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> (m_tuser == KIND_TIME_BYTE || m_tuser == KIND_TIME_BAD))
    else $error("run ends on a date beat");

  // invalid markers carry a zero byte
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == KIND_DATE_BAD || m_tuser == KIND_TIME_BAD)) |-> (m_tdata == 8'd0))
    else $error("invalid span marker with non-zero byte");
`endif

endmodule

`default_nettype wire

FILE: test/testbench.sv
// testbench for the log line pattern filter: directed and random byte streams, self-checking
`default_nettype none

module testbench;
  import lpf_pkg::*;

  localparam int CAPTURE        = 16;
  localparam int LINE_LIMIT     = 1024;
  localparam int RANDOM_BEATS   = 50;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 4000;

  // one result beat as the block presents it
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
    logic       tail;
  } filter_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = REG_PATTERN_LOW;
  logic [63:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic [0:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;

  log_line_pattern_filter_top u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),    // [7:0] data_byte
    .s_tuser  (s_tuser),    // [0] end_of_stream
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),    // [7:0] result_byte
    .m_tuser  (m_tuser),    // [1:0] result_kind
    .m_tlast  (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // line filter prediction: own copy of the registers and the line state
  // ---------------------------------------------------------------------------
  logic [PAT_W-1:0]       match_pattern = '0;
  logic [4:0]             match_len = 5'd1;
  int                     date_first = 0;
  int                     date_past = 6;
  int                     time_first = 8;
  int                     time_past = 16;
  logic [8*PAT_BYTES-1:0] window = '0;      // byte 0 is the newest
  int                     column = 0;       // bytes held in the current line
  logic                   line_hit = 1'b0;
  logic [8*CAPTURE-1:0]   date_bytes = '0;
  logic [8*CAPTURE-1:0]   time_bytes = '0;

  filter_result_t expected_results[$];

  // pattern length as the compare uses it: zero counts as one, clipped to the store
  function automatic int compare_len();
    int n;
    n = int'(match_len);
    if (n == 0) n = 1;
    if (n > PAT_BYTES) n = PAT_BYTES;
    return n;
  endfunction

  // one marker for a span outside the line, else its first CAPTURE bytes
  function automatic void expect_span(input logic [1:0] ok_kind, input logic [1:0] bad_kind,
                                      input logic [8*CAPTURE-1:0] bytes, input int first,
                                      input int past, input int len, input logic is_tail);
    filter_result_t r;
    int             cnt, i;
    if (past > first && past > 0 && first < len && past <= len) begin
      cnt = past - first;
      if (cnt > CAPTURE) cnt = CAPTURE;
      for (i = 0; i < cnt; i++) begin
        r.kind  = ok_kind;
        r.value = bytes[8*i +: 8];
        r.tail  = is_tail && (i == cnt - 1);
        expected_results.push_back(r);
      end
    end else begin
      r.kind  = bad_kind;
      r.value = 8'd0;
      r.tail  = is_tail;
      expected_results.push_back(r);
    end
  endfunction

  function automatic void predict_beat(input logic [7:0] value, input logic eos);
    int   plen, k;
    logic hit;
    if (eos) begin
      // partial line dropped, registers and window kept
      column   = 0;
      line_hit = 1'b0;
    end else if (value == BYTE_LF || value == BYTE_NUL) begin
      if (line_hit) begin
        expect_span(KIND_DATE_BYTE, KIND_DATE_BAD, date_bytes, date_first, date_past,
                    column, 1'b0);
        expect_span(KIND_TIME_BYTE, KIND_TIME_BAD, time_bytes, time_first, time_past,
                    column, 1'b1);
      end
      column   = 0;
      line_hit = 1'b0;
    end else begin
      // nothing is captured once the line position has saturated
      if (column < LINE_LIMIT) begin
        if (column >= date_first && column < date_past && column - date_first < CAPTURE)
          date_bytes[8*(column - date_first) +: 8] = value;
        if (column >= time_first && column < time_past && column - time_first < CAPTURE)
          time_bytes[8*(column - time_first) +: 8] = value;
        column++;
      end
      window = {window[8*(PAT_BYTES-1)-1:0], value};
      plen = compare_len();
      // whole window compared, last pattern byte included
      if (column >= plen) begin
        hit = 1'b1;
        for (k = 0; k < plen; k++)
          if (window[8*(plen-1-k) +: 8] != match_pattern[8*k +: 8]) hit = 1'b0;
        if (hit) line_hit = 1'b1;
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------
  int             failures = 0;
  filter_result_t got_result, want_result;

  function automatic void note_failure(input string text);
    failures++;
    if (failures <= 10) $display("%s", text);
  endfunction

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_result.kind  = m_tuser;
      got_result.value = m_tdata;
      got_result.tail  = m_tlast;
      if (expected_results.size() == 0) begin
        note_failure($sformatf("unexpected result beat: kind %0d byte %02h last %b",
                               got_result.kind, got_result.value, got_result.tail));
      end else begin
        want_result = expected_results.pop_front();
        if (got_result.kind !== want_result.kind || got_result.value !== want_result.value ||
            got_result.tail !== want_result.tail)
          note_failure($sformatf(
            "result mismatch: expected kind %0d byte %02h last %b, got kind %0d byte %02h last %b",
            want_result.kind, want_result.value, want_result.tail,
            got_result.kind, got_result.value, got_result.tail));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: changing stall pattern, plus a long hold-off when the tests ask
  // ---------------------------------------------------------------------------
  int hold_asked = 0;   // bumped by the tests
  int hold_taken = 0;
  int hold_left  = 0;
  int rx_tick    = 0;
  int rx_mode    = 0;

  always @(posedge clk) begin
    rx_tick <= rx_tick + 1;
    if (hold_left != 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_taken != hold_asked) begin
      // long stall so the block backs up and stops taking bytes
      hold_taken <= hold_asked;
      hold_left  <= HOLD_CYCLES;
      m_tready   <= 1'b0;
    end else begin
      if (rx_tick % 64 == 0) rx_mode <= $urandom_range(0, 3);
      case (rx_mode)
        0: begin
          m_tready <= 1'b1;
        end
        1: begin
          m_tready <= 1'($urandom_range(0, 1));
        end
        2: begin
          m_tready <= ($urandom_range(0, 3) == 0);
        end
        default: begin
          m_tready <= (rx_tick % 4 != 3);
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: ends the run when nothing moves for too long
  // ---------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // byte sender: bursts of random length; a sender that is not steady leaves random gaps in between
  // ---------------------------------------------------------------------------
  int burst_left    = 1;
  int pending_gap   = 0;
  int beats_sent    = 0;
  bit steady_sender = 1'b0;

  task automatic send_beat(input logic [7:0] value, input logic eos);
    repeat (pending_gap) @(posedge clk);
    pending_gap = 0;
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    s_tuser  <= eos;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_beat(value, eos);
    beats_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 16);
      // valid stays high straight into the next burst when the sender is steady
      if (!steady_sender) begin
        pending_gap = $urandom_range(1, 6);
        s_tvalid <= 1'b0;
      end
    end
  endtask

  task automatic send_text(input string text);
    int i;
    for (i = 0; i < text.len(); i++) send_beat(text[i], 1'b0);
  endtask

  // lower valid after the last beat unless a gap already did
  task automatic stop_sending;
    if (pending_gap == 0) s_tvalid <= 1'b0;
    pending_gap = 1;
  endtask

  // all results in, then a wait for a line end that gave nothing
  task automatic wait_drain;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic finish_phase;
    stop_sending();
    wait_drain();
  endtask

  // ---------------------------------------------------------------------------
  // register writes, only while the block is idle
  // ---------------------------------------------------------------------------
  task automatic write_reg(input logic [2:0] index, input logic [63:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (index)
      REG_PATTERN_LOW:    match_pattern[63:0]    = value;
      REG_PATTERN_MID:    match_pattern[127:64]  = value;
      REG_PATTERN_HIGH:   match_pattern[191:128] = value;
      REG_PATTERN_LENGTH: match_len              = value[4:0];
      REG_DATE_START:     date_first             = int'(value[9:0]);
      REG_DATE_END:       date_past              = int'(value[10:0]);
      REG_TIME_START:     time_first             = int'(value[9:0]);
      default:            time_past              = int'(value[10:0]);
    endcase
    @(posedge clk);
  endtask

  // eight pattern bytes of a text, zeros beyond its end
  function automatic logic [63:0] text_word(input string text, input int first);
    logic [63:0] word;
    int          k;
    word = '0;
    for (k = 0; k < 8; k++)
      if (first + k < text.len()) word[8*k +: 8] = text[first + k];
    return word;
  endfunction

  task automatic set_pattern(input string text, input logic [4:0] len);
    write_reg(REG_PATTERN_LOW, text_word(text, 0));
    write_reg(REG_PATTERN_MID, text_word(text, 8));
    write_reg(REG_PATTERN_HIGH, text_word(text, 16));
    write_reg(REG_PATTERN_LENGTH, 64'(len));
  endtask

  task automatic set_spans(input int d_first, input int d_past, input int t_first,
                           input int t_past);
    write_reg(REG_DATE_START, 64'(d_first));
    write_reg(REG_DATE_END, 64'(d_past));
    write_reg(REG_TIME_START, 64'(t_first));
    write_reg(REG_TIME_END, 64'(t_past));
  endtask

  function automatic logic [7:0] letter();
    return 8'h61 + 8'($urandom_range(0, 3));
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset values: a zero pattern byte can never be in a line, then default spans
  task automatic test_default_spans;
    send_text("a\n");
    finish_phase();
    write_reg(REG_PATTERN_LOW, text_word("*", 0));
    send_text("day-01  tm:12:34 *\n");
    finish_phase();
  endtask

  // both terminators, extreme bytes, short lines, end of stream
  task automatic test_terminators_and_windows;
    set_pattern("ab", 5'd2);
    set_spans(0, 2, 2, 4);
    send_text("ab");
    send_beat(8'hff, 1'b0);
    send_beat(8'h01, 1'b0);
    send_beat(BYTE_LF, 1'b0);
    // line too short for the time span
    send_text("ab");
    send_beat(BYTE_NUL, 1'b0);
    // pattern straddles two lines: the window must not match
    send_text("a\nb\n");
    // end of stream drops a hit line, its data byte ignored
    send_text("ab");
    send_beat(BYTE_LF, 1'b1);
    send_beat(BYTE_LF, 1'b0);
    send_text("xaby\n");
    finish_phase();
  endtask

  // length zero, length clipped to the store, full compare of the last byte
  task automatic test_length_clamps;
    set_pattern("q", 5'd0);
    send_text("pq\n");
    finish_phase();
    set_pattern("ABCDEFGHIJKLMNOPQRSTUVWX", 5'd31);
    send_text("ABCDEFGHIJKLMNOPQRSTUVWX\n");
    finish_phase();
    set_pattern("authentication failure", 5'd22);
    set_spans(0, 4, 5, 9);
    send_text("0412 1530 authentication failure\n");
    send_text("0412 1530 authentication failurx\n");
    finish_phase();
  endtask

  // long span clipped to the capture depth, then both spans invalid
  task automatic test_long_span;
    int i;
    set_pattern("!", 5'd1);
    set_spans(0, 20, 2, 3);
    for (i = 0; i < 20; i++) send_beat(letter(), 1'b0);
    send_text("!\n");
    finish_phase();
    set_spans(1023, 2047, 5, 5);
    send_text("!\n");
    finish_phase();
  endtask

  // spans at the end of the line: one ends on the last byte, one runs past it
  task automatic test_span_edges;
    set_pattern("ERR", 5'd3);
    set_spans(4, 10, 6, 11);
    send_text("abERRcdefg\n");
    // both spans start beyond a short line
    send_text("ERR\n");
    finish_phase();
  endtask

  task automatic pick_span(output int first, output int past);
    case ($urandom_range(0, 9))
      0: begin
        first = 1023;
        past  = 2047;
      end
      1: begin
        first = $urandom_range(0, 12);
        past  = $urandom_range(0, 1) ? 0 : first;
      end
      2: begin
        first = $urandom_range(0, 3);
        past  = first + $urandom_range(17, 26);
      end
      default: begin
        first = $urandom_range(0, 14);
        past  = first + $urandom_range(1, 10);
      end
    endcase
  endtask

  // random pattern word: alphabet bytes inside the compared length, noise above
  function automatic logic [63:0] pattern_word(input int first, input int plen);
    logic [63:0] word;
    int          k;
    word = {$urandom, $urandom};
    for (k = 0; k < 8; k++)
      if (first + k < plen) word[8*k +: 8] = letter();
    return word;
  endfunction

  task automatic random_config;
    logic [4:0] len_value;
    int         plen, d_first, d_past, t_first, t_past;
    case ($urandom_range(0, 9))
      0: len_value = 5'd0;
      1: len_value = 5'($urandom_range(25, 31));
      2: len_value = 5'd24;
      default: len_value = 5'($urandom_range(1, 4));
    endcase
    plen = (len_value == 5'd0) ? 1 : (int'(len_value) > PAT_BYTES) ? PAT_BYTES :
           int'(len_value);
    write_reg(REG_PATTERN_LOW, pattern_word(0, plen));
    write_reg(REG_PATTERN_MID, pattern_word(8, plen));
    write_reg(REG_PATTERN_HIGH, pattern_word(16, plen));
    write_reg(REG_PATTERN_LENGTH, 64'(len_value));
    pick_span(d_first, d_past);
    pick_span(t_first, t_past);
    set_spans(d_first, d_past, t_first, t_past);
  endtask

  task automatic random_line;
    int         shape, fill, at, k, j, plen;
    logic [7:0] b;
    plen  = compare_len();
    shape = $urandom_range(0, 9);
    if (shape == 0) begin
      // noise: any byte, terminators and end of stream included
      repeat ($urandom_range(1, 6))
        send_beat(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
    end else if (shape == 1) begin
      // broken: the start of the pattern, then end of stream
      fill = $urandom_range(0, plen);
      for (k = 0; k < fill; k++) send_beat(match_pattern[8*k +: 8], 1'b0);
      send_beat(8'($urandom_range(0, 255)), 1'b1);
    end else begin
      // well formed: random text, mostly with the pattern somewhere in it
      fill = $urandom_range(0, 20);
      at   = ($urandom_range(0, 9) < 7) ? $urandom_range(0, fill) : -1;
      for (k = 0; k <= fill; k++) begin
        if (k == at)
          for (j = 0; j < plen; j++) send_beat(match_pattern[8*j +: 8], 1'b0);
        if (k < fill) begin
          if ($urandom_range(0, 7) == 0) begin
            b = 8'($urandom_range(1, 255));
            if (b == BYTE_LF) b = 8'h0b;
          end else begin
            b = letter();
          end
          send_beat(b, 1'b0);
        end
      end
      send_beat($urandom_range(0, 1) ? BYTE_LF : BYTE_NUL, 1'b0);
    end
  endtask

  // random lines over changing settings; the first phase holds the receiver off
  task automatic test_random_lines;
    int first_beat, phase;
    first_beat = beats_sent;
    phase      = 0;
    while (beats_sent - first_beat < RANDOM_BEATS) begin
      random_config();
      steady_sender = (phase % 2 == 1);
      if (phase == 0) hold_asked <= hold_asked + 1;
      repeat ($urandom_range(2, 5)) random_line();
      // close any line the noise left open
      send_beat(BYTE_LF, 1'b0);
      finish_phase();
      phase++;
    end
    steady_sender = 1'b0;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_default_spans();
    test_terminators_and_windows();
    test_length_clamps();
    test_long_span();
    test_span_edges();
    test_random_lines();
    wait_drain();
    repeat (16) @(posedge clk);
    if (failures == 0 && expected_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: sim.f
rtl/core/lpf_pkg.sv
rtl/core/lpf_line.sv
rtl/core/lpf_emit.sv
rtl/core/log_line_pattern_filter_top.sv
test/testbench.sv
